FILE: hdl/dhtq_pkg.sv
// Shared types, codes and helpers for the deadline heap timer queue.
package dhtq_pkg;

  localparam int ID_W   = 8;
  localparam int TIME_W = 48;
  localparam int PER_W  = 32;
  localparam int LIM_W  = 6;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 6'd63;

  // Opcodes of an input beat
  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FIRED     = 3'd5;
  localparam logic [2:0] ST_NOTHING   = 3'd6;

  // One heap slot as stored in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] dl;
    logic [PER_W-1:0]  per;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [4:0] {
    S_IDLE,
    S_EMIT,
    S_SU_CHK,
    S_SU_CMP,
    S_SD_CHK,
    S_SD_C1,
    S_SD_C2,
    S_SD_CMP,
    S_CN_CHK,
    S_CN_CMP,
    S_CN_TAIL,
    S_TK_CHK,
    S_TK_CMP,
    S_TK_POP,
    S_TK_TAIL,
    S_TK_REINS,
    S_TK_NEXT,
    S_TK_END
  } state_t;

  // Where a sift returns to when it settles
  typedef enum logic [1:0] {
    RET_EMIT,
    RET_TK_REINS,
    RET_TK_NEXT
  } ret_t;

  // Add a period to a deadline, saturating at the top of the time range
  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [PER_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W+1-PER_W){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

FILE: hdl/dhtq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dhtq_ram #(
  parameter int WIDTH = 88,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/deadline_heap_timer_queue.sv
// Timer queue top level: binary min-heap of deadlines kept in one slot memory.
//
// Timers live in a binary min-heap stored in one slot memory (id, deadline,
// period per slot) with a registered read. A sequencer walks the heap one
// memory access at a time: a schedule sifts the new timer up toward the root,
// a cancel scans the slots in array order and then moves the tail into the
// hole, and a tick pops each due root, sifts the tail down from the root and
// reinserts a periodic timer. The input is stalled while an item is in work;
// results leave through an output register, and a tick gives one beat per
// fired timer (last marks the final one) or one "nothing due" beat. No memory
// clearing pass is needed: only slots below the entry count are ever read.
module deadline_heap_timer_queue
  import dhtq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [LIM_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [ID_W-1:0]   timer_id,
  input  logic [TIME_W-1:0] due_time,
  input  logic [PER_W-1:0]  period,
  input  logic [TIME_W-1:0] now_time,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [ID_W-1:0]   result_id,
  output logic [TIME_W-1:0] result_time,
  output logic              last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;

  state_t            state, state_next;
  ret_t              ret, ret_next;
  logic [CW-1:0]     count, count_next;
  logic [TIME_W-1:0] last_tick, last_tick_next;
  logic [LIM_W-1:0]  max_fires, max_fires_next;
  logic [AW-1:0]     pos, pos_next;
  entry_t            cur, cur_next;
  entry_t            pick, pick_next;
  logic [AW-1:0]     pick_idx, pick_idx_next;
  entry_t            fired, fired_next;
  logic [TIME_W-1:0] old_dl, old_dl_next;
  logic [CW-1:0]     scan_i, scan_i_next;
  logic [2:0]        res_status, res_status_next;
  logic [ID_W-1:0]   res_id, res_id_next;
  logic              have_pend, have_pend_next;
  logic [LIM_W-1:0]  nfire, nfire_next;
  logic              out_valid_next;
  logic [2:0]        status_next;
  logic [ID_W-1:0]   result_id_next;
  logic [TIME_W-1:0] result_time_next;
  logic              last_next;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  logic [AW-1:0]     rd_addr;
  entry_t            q;
  logic              out_free;
  logic [AW-1:0]     parent;
  logic [XW-1:0]     c1, c2, n_x, half_x, pos_x;
  logic [LIM_W-1:0]  limit;
  logic [CW-1:0]     count_dec;

  dhtq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(q)
  );

  // Heap index arithmetic
  assign parent    = AW'((pos - AW'(1)) >> 1);
  assign pos_x     = XW'(pos);
  assign c1        = (pos_x << 1) + XW'(1);
  assign c2        = c1 + XW'(1);
  assign n_x       = XW'(count);
  assign half_x    = n_x >> 1;
  assign limit     = (max_fires == '0) ? LIM_W'(1) : max_fires;
  assign count_dec = count - CW'(1);
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      last_tick <= '0;
      max_fires <= LIMIT_RESET;
      out_valid <= 1'b0;
      have_pend <= 1'b0;
      nfire     <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      last_tick <= last_tick_next;
      max_fires <= max_fires_next;
      out_valid <= out_valid_next;
      have_pend <= have_pend_next;
      nfire     <= nfire_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ret         <= ret_next;
    pos         <= pos_next;
    cur         <= cur_next;
    pick        <= pick_next;
    pick_idx    <= pick_idx_next;
    fired       <= fired_next;
    old_dl      <= old_dl_next;
    scan_i      <= scan_i_next;
    res_status  <= res_status_next;
    res_id      <= res_id_next;
    status      <= status_next;
    result_id   <= result_id_next;
    result_time <= result_time_next;
    last        <= last_next;
  end

  // Sequencer: next state, memory access and result beats
  always_comb begin
    state_next       = state;
    ret_next         = ret;
    count_next       = count;
    last_tick_next   = last_tick;
    max_fires_next   = cfg_we ? cfg_data : max_fires;
    pos_next         = pos;
    cur_next         = cur;
    pick_next        = pick;
    pick_idx_next    = pick_idx;
    fired_next       = fired;
    old_dl_next      = old_dl;
    scan_i_next      = scan_i;
    res_status_next  = res_status;
    res_id_next      = res_id;
    have_pend_next   = have_pend;
    nfire_next       = nfire;
    out_valid_next   = out_valid && out_stall;
    status_next      = status;
    result_id_next   = result_id;
    result_time_next = result_time;
    last_next        = last;
    wr_en            = 1'b0;
    wr_addr          = pos;
    wr_data          = cur;
    rd_addr          = pos;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_id_next = timer_id;
          ret_next    = RET_EMIT;
          case (opcode)
            OP_SCHEDULE: begin
              if (due_time == '0 && period == '0) begin
                res_status_next = ST_INVALID;
                state_next      = S_EMIT;
              end else if (count == CW'(DEPTH)) begin
                res_status_next = ST_FULL;
                state_next      = S_EMIT;
              end else begin
                res_status_next = ST_ACCEPTED;
                cur_next.id     = timer_id;
                cur_next.dl     = (due_time != '0) ? due_time : sat_add(last_tick, period);
                cur_next.per    = period;
                pos_next        = AW'(count);
                count_next      = count + CW'(1);
                state_next      = S_SU_CHK;
              end
            end
            OP_CANCEL: begin
              scan_i_next = '0;
              state_next  = S_CN_CHK;
            end
            OP_TICK: begin
              last_tick_next = now_time;
              nfire_next     = '0;
              have_pend_next = 1'b0;
              state_next     = S_TK_CHK;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // Deliver the single result of a schedule or cancel
      S_EMIT: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          status_next      = res_status;
          result_id_next   = res_id;
          result_time_next = '0;
          last_next        = 1'b1;
          state_next       = S_IDLE;
        end
      end

      // Sift up: move the hole toward the root
      S_SU_CHK: begin
        if (pos == '0) begin
          wr_en = 1'b1;
          case (ret)
            RET_TK_REINS: state_next = S_TK_REINS;
            RET_TK_NEXT:  state_next = S_TK_NEXT;
            default:      state_next = S_EMIT;
          endcase
        end else begin
          rd_addr    = parent;
          state_next = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        wr_en = 1'b1;
        if (cur.dl < q.dl) begin
          wr_data    = q;
          pos_next   = parent;
          state_next = S_SU_CHK;
        end else begin
          case (ret)
            RET_TK_REINS: state_next = S_TK_REINS;
            RET_TK_NEXT:  state_next = S_TK_NEXT;
            default:      state_next = S_EMIT;
          endcase
        end
      end

      // Sift down: move the hole toward the leaves
      S_SD_CHK: begin
        if (pos_x >= half_x) begin
          wr_en = 1'b1;
          case (ret)
            RET_TK_REINS: state_next = S_TK_REINS;
            RET_TK_NEXT:  state_next = S_TK_NEXT;
            default:      state_next = S_EMIT;
          endcase
        end else begin
          rd_addr    = AW'(c1);
          state_next = S_SD_C1;
        end
      end
      S_SD_C1: begin
        pick_next     = q;
        pick_idx_next = AW'(c1);
        if (c2 < n_x) begin
          rd_addr    = AW'(c2);
          state_next = S_SD_C2;
        end else begin
          state_next = S_SD_CMP;
        end
      end
      S_SD_C2: begin
        if (q.dl < pick.dl) begin
          pick_next     = q;
          pick_idx_next = AW'(c2);
        end
        state_next = S_SD_CMP;
      end
      S_SD_CMP: begin
        wr_en = 1'b1;
        if (pick.dl < cur.dl) begin
          wr_data    = pick;
          pos_next   = pick_idx;
          state_next = S_SD_CHK;
        end else begin
          case (ret)
            RET_TK_REINS: state_next = S_TK_REINS;
            RET_TK_NEXT:  state_next = S_TK_NEXT;
            default:      state_next = S_EMIT;
          endcase
        end
      end

      // Cancel: scan slots in array order for the id
      S_CN_CHK: begin
        if (scan_i >= count) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_EMIT;
        end else begin
          rd_addr    = AW'(scan_i);
          state_next = S_CN_CMP;
        end
      end
      S_CN_CMP: begin
        if (q.id == res_id) begin
          res_status_next = ST_CANCELLED;
          old_dl_next     = q.dl;
          count_next      = count_dec;
          pos_next        = AW'(scan_i);
          if (scan_i < count_dec) begin
            rd_addr    = AW'(count_dec);
            state_next = S_CN_TAIL;
          end else begin
            state_next = S_EMIT;
          end
        end else begin
          scan_i_next = scan_i + CW'(1);
          state_next  = S_CN_CHK;
        end
      end
      S_CN_TAIL: begin
        cur_next = q;
        if (q.dl > old_dl) begin
          state_next = S_SD_CHK;
        end else if (q.dl < old_dl) begin
          state_next = S_SU_CHK;
        end else begin
          wr_en      = 1'b1;
          wr_data    = q;
          state_next = S_EMIT;
        end
      end

      // Tick: pop due roots up to the fire limit
      S_TK_CHK: begin
        if (count == '0) begin
          state_next = S_TK_END;
        end else begin
          rd_addr    = '0;
          state_next = S_TK_CMP;
        end
      end
      S_TK_CMP: begin
        fired_next = q;
        if (q.dl <= last_tick && nfire < limit) begin
          state_next = S_TK_POP;
        end else begin
          state_next = S_TK_END;
        end
      end
      S_TK_POP: begin
        if (!have_pend || out_free) begin
          if (have_pend) begin
            out_valid_next   = 1'b1;
            status_next      = ST_FIRED;
            result_id_next   = pick.id;
            result_time_next = pick.dl;
            last_next        = 1'b0;
            have_pend_next   = 1'b0;
          end
          count_next = count_dec;
          if (count_dec != '0) begin
            rd_addr    = AW'(count_dec);
            state_next = S_TK_TAIL;
          end else begin
            state_next = S_TK_REINS;
          end
        end
      end
      S_TK_TAIL: begin
        cur_next   = q;
        pos_next   = '0;
        ret_next   = RET_TK_REINS;
        state_next = S_SD_CHK;
      end
      S_TK_REINS: begin
        if (fired.per != '0) begin
          cur_next.id  = fired.id;
          cur_next.dl  = sat_add(fired.dl, fired.per);
          cur_next.per = fired.per;
          pos_next     = AW'(count);
          count_next   = count + CW'(1);
          ret_next     = RET_TK_NEXT;
          state_next   = S_SU_CHK;
        end else begin
          state_next = S_TK_NEXT;
        end
      end
      S_TK_NEXT: begin
        // Park the fired timer until it is known whether another follows
        pick_next      = fired;
        have_pend_next = 1'b1;
        nfire_next     = nfire + LIM_W'(1);
        state_next     = S_TK_CHK;
      end
      S_TK_END: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          last_next      = 1'b1;
          if (have_pend) begin
            status_next      = ST_FIRED;
            result_id_next   = pick.id;
            result_time_next = pick.dl;
          end else begin
            status_next      = ST_NOTHING;
            result_id_next   = '0;
            result_time_next = '0;
          end
          have_pend_next = 1'b0;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Heap never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // Every slot write lands inside the live heap
  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW'(wr_addr) < count))
    else $error("slot write outside live heap");

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(result_id) &&
                                  $stable(result_time) && $stable(last)))
    else $error("stalled result beat changed");

  // A tick never fires more than its limit
  a_fire_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_TK_POP) |-> (nfire < limit))
    else $error("fire limit exceeded");

endmodule
